@@ sv/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keyed cache: key and LFSR widths,
// operation, mode and status codes, and the per-cell update command.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KEY_W  = 31;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // operation codes
    localparam logic OP_STORE    = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    // replacement modes
    localparam logic MODE_LRU    = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_HIT      = 2'd0;
    localparam t_status ST_BACKING  = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_STORED   = 2'd3;

    // update command broadcast to every cell
    typedef struct packed {
        logic en;        // apply an update this cycle
        logic age_all;   // age every valid entry (plain insert)
        logic load_key;  // target takes the new key
    } t_cell_cmd;

endpackage

@@ sv/kcl_cell.sv @@
// ----------------------------------------------------------------------------
// kcl_cell
// One cache entry: valid bit, key and recency rank. Compares the lookup key,
// joins the free-slot priority chain and the select readout chains that run
// from neighbor to neighbor, and applies the broadcast update command.
// ----------------------------------------------------------------------------
module kcl_cell #(
    parameter int AW = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // lookup
    input  logic [kcl_pkg::KEY_W-1:0] i_look_key,
    output logic                     o_hit,
    // free-slot chain
    input  logic                     i_free_seen,
    output logic                     o_free_seen,
    output logic                     o_free_first,
    // readout chains
    input  logic                     i_sel,
    input  logic [AW-1:0]            i_age_chain,
    output logic [AW-1:0]            o_age_chain,
    input  logic [kcl_pkg::KEY_W-1:0] i_key_chain,
    output logic [kcl_pkg::KEY_W-1:0] o_key_chain,
    // state view
    output logic                     o_valid,
    output logic [AW-1:0]            o_age,
    // update
    input  kcl_pkg::t_cell_cmd       i_cmd,
    input  logic                     i_tgt,
    input  logic [AW-1:0]            i_thresh,
    input  logic [kcl_pkg::KEY_W-1:0] i_new_key
);

    logic                      r_valid;
    logic [kcl_pkg::KEY_W-1:0] r_key;
    logic [AW-1:0]             r_age;

    // compare and chains
    assign o_hit        = r_valid && (r_key == i_look_key);
    assign o_free_seen  = i_free_seen | ~r_valid;
    assign o_free_first = ~r_valid & ~i_free_seen;
    assign o_age_chain  = i_age_chain | (i_sel ? r_age : '0);
    assign o_key_chain  = i_key_chain | (i_sel ? r_key : '0);
    assign o_valid      = r_valid;
    assign o_age        = r_age;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.en && i_tgt) begin
            r_valid <= 1'b1;
        end
    end

    // key and rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_tgt) begin
                r_age <= '0;
                if (i_cmd.load_key) begin
                    r_key <= i_new_key;
                end
            end else if (r_valid && (i_cmd.age_all || (r_age < i_thresh))) begin
                r_age <= r_age + AW'(1);
            end
        end
    end

endmodule

@@ sv/kcl_victim_rng.sv @@
// ----------------------------------------------------------------------------
// kcl_victim_rng
// 16-bit Galois LFSR for random victim choice. The next LFSR value is reduced
// modulo the entry count by a registered reciprocal multiply, then a
// multiply-back, subtract and one correction step.
// ----------------------------------------------------------------------------
module kcl_victim_rng #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    output logic [IW-1:0] o_slot
);

    localparam int LW = kcl_pkg::LFSR_W;
    localparam int NW = $clog2(N + 1);
    localparam int PW = LW + 32;
    localparam int RW = LW + NW;
    localparam logic [31:0] RECIP =
        32'(((64'd1 << 32) + 64'(N) - 64'd1) / 64'(N));

    logic [LW-1:0] r_lfsr;
    logic [LW-1:0] n_lfsr;
    logic [LW-1:0] r_x;
    logic [PW-1:0] r_prod;
    logic [LW-1:0] quo;
    logic [RW-1:0] rem;
    logic [RW-1:0] rem_fix;

    // next LFSR value
    assign n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? kcl_pkg::LFSR_TAPS : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= kcl_pkg::LFSR_SEED;
        end else if (i_advance) begin
            r_lfsr <= n_lfsr;
        end
    end

    // quotient estimate, registered
    always_ff @(posedge i_clk) begin
        r_x    <= n_lfsr;
        r_prod <= PW'(n_lfsr) * PW'(RECIP);
    end

    // remainder with one correction
    assign quo     = r_prod[PW-1:32];
    assign rem     = RW'(r_x) - RW'(RW'(quo) * RW'(N));
    assign rem_fix = (rem >= RW'(N)) ? rem - RW'(N) : rem;
    assign o_slot  = rem_fix[IW-1:0];

endmodule

@@ sv/keyed_cache_lru_random_replace.sv @@
// ----------------------------------------------------------------------------
// keyed_cache_lru_random_replace
// Fully associative key cache built as a row of entry cells, with LRU or
// pseudo-random replacement.
// ----------------------------------------------------------------------------
// Each item is accepted in S_IDLE; in S_LOOK the key is compared against every
// cell and the free-slot chain runs, and in S_UPDATE the victim is picked and
// all cells are updated. The result is registered at the end of S_UPDATE, and
// the next item can be accepted once the sequencer is back in S_IDLE. The
// random victim comes from a registered reciprocal multiply of the LFSR, and
// the rank/key readout chains across the cells set the update-cycle path. A
// new item is taken once the previous one has left the update cycle; the
// result sits in an output register until taken, and the update cycle waits
// only while that register is still full. The cache needs no clearing pass.
// ----------------------------------------------------------------------------
module keyed_cache_lru_random_replace #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data,
    // input items
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_operation,
    input  logic [kcl_pkg::KEY_W-1:0] i_key,
    input  logic                      i_in_backing,
    // result items
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic                      o_evicted_valid,
    output logic [kcl_pkg::KEY_W-1:0] o_evicted_key
);

    localparam int N  = CACHE_ENTRIES;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic                      r_mode;
    logic [CW-1:0]             r_count;
    logic                      r_op;
    logic [kcl_pkg::KEY_W-1:0] r_key;
    logic                      r_backing;
    logic [N-1:0]              r_hit_vec;
    logic                      r_any_hit;
    logic [AW-1:0]             r_hit_age;
    logic [N-1:0]              r_free_vec;
    logic                      r_o_valid;
    kcl_pkg::t_status          r_o_status;
    logic                      r_o_ev_valid;
    logic [kcl_pkg::KEY_W-1:0] r_o_ev_key;

    logic [N-1:0]              hit_vec;
    logic [N-1:0]              free_vec;
    logic [N-1:0]              victim_vec;
    logic [N-1:0]              sel_vec;
    logic [N-1:0]              tgt_vec;
    logic [N-1:0]              cell_valid;
    logic [AW-1:0]             cell_age   [N];
    logic [N:0]                free_chain;
    logic [AW-1:0]             age_chain  [N+1];
    logic [kcl_pkg::KEY_W-1:0] key_chain  [N+1];
    logic [AW-1:0]             rand_slot;
    logic [AW-1:0]             thresh;
    kcl_pkg::t_cell_cmd        cmd;
    kcl_pkg::t_status          status;
    logic                      full;
    logic                      insert_req;
    logic                      evict;
    logic                      out_free;
    logic                      go;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign out_free    = !r_o_valid || i_ready;
    assign go          = (r_state == S_UPDATE) && out_free;

    // replacement mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kcl_pkg::MODE_LRU;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_LOOK;
            S_LOOK:   n_state = S_UPDATE;
            S_UPDATE: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op      <= i_operation;
            r_key     <= i_key;
            r_backing <= i_in_backing;
        end
    end

    // lookup results
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_hit_vec  <= hit_vec;
            r_any_hit  <= |hit_vec;
            r_hit_age  <= age_chain[N];
            r_free_vec <= free_vec;
        end
    end

    // random victim slot
    kcl_victim_rng #(
        .N  (N),
        .IW (AW)
    ) u_rng (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (go && evict && (r_mode == kcl_pkg::MODE_RANDOM)),
        .o_slot    (rand_slot)
    );

    // cell row
    assign free_chain[0] = 1'b0;
    assign age_chain[0]  = '0;
    assign key_chain[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            assign victim_vec[gi] = (r_mode == kcl_pkg::MODE_RANDOM)
                ? (rand_slot == AW'(gi))
                : (cell_valid[gi] && (cell_age[gi] == AW'(N - 1)));
            assign sel_vec[gi] = (r_state == S_LOOK) ? hit_vec[gi] : victim_vec[gi];

            kcl_cell #(
                .AW (AW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_look_key   (r_key),
                .o_hit        (hit_vec[gi]),
                .i_free_seen  (free_chain[gi]),
                .o_free_seen  (free_chain[gi+1]),
                .o_free_first (free_vec[gi]),
                .i_sel        (sel_vec[gi]),
                .i_age_chain  (age_chain[gi]),
                .o_age_chain  (age_chain[gi+1]),
                .i_key_chain  (key_chain[gi]),
                .o_key_chain  (key_chain[gi+1]),
                .o_valid      (cell_valid[gi]),
                .o_age        (cell_age[gi]),
                .i_cmd        (cmd),
                .i_tgt        (tgt_vec[gi]),
                .i_thresh     (thresh),
                .i_new_key    (r_key)
            );
        end
    endgenerate

    // update decision
    assign full       = (r_count == CW'(N));
    assign insert_req = !r_any_hit && ((r_op == kcl_pkg::OP_STORE) || r_backing);
    assign evict      = insert_req && full;
    assign tgt_vec    = r_any_hit ? r_hit_vec : (evict ? victim_vec : r_free_vec);
    assign thresh     = r_any_hit ? r_hit_age : age_chain[N];

    always_comb begin
        cmd.en       = go && (r_any_hit || insert_req);
        cmd.age_all  = !r_any_hit && !evict;
        cmd.load_key = !r_any_hit;
    end

    always_comb begin
        if (r_any_hit) begin
            status = (r_op == kcl_pkg::OP_RETRIEVE) ? kcl_pkg::ST_HIT : kcl_pkg::ST_STORED;
        end else if (insert_req) begin
            status = (r_op == kcl_pkg::OP_STORE) ? kcl_pkg::ST_STORED : kcl_pkg::ST_BACKING;
        end else begin
            status = kcl_pkg::ST_NOTFOUND;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (go && insert_req && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (go) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_o_status   <= status;
            r_o_ev_valid <= evict;
            r_o_ev_key   <= evict ? key_chain[N] : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_key   = r_o_ev_key;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("fill count above entry count");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $onehot0(hit_vec))
        else $error("key cached in more than one entry");

    a_victim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && full) |-> $onehot(victim_vec))
        else $error("full cache without exactly one victim");

    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && evict |=> (r_o_status == kcl_pkg::ST_STORED ||
                         r_o_status == kcl_pkg::ST_BACKING))
        else $error("eviction reported with a non-insert status");

endmodule

@@ test/tb_keyed_cache_lru_random_replace.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_cache_lru_random_replace
// Self-checking testbench for the keyed cache. A behavioral mirror of the
// cache (entries, ranks, LFSR) predicts status and eviction for every item.
// A short directed table comes first, then random traffic over key pools of
// varying size, in both replacement modes, under bursty input and stalls.
// ----------------------------------------------------------------------------
module tb_keyed_cache_lru_random_replace;

    localparam int                        ENTRIES     = 16;
    localparam int                        POOL        = 40;
    localparam int                        PHASE_ITEMS = 90;
    localparam int                        STALL_LIMIT = 2000;
    localparam int                        SETTLE      = 4;
    localparam logic [kcl_pkg::KEY_W-1:0] KEY_MAX     = {kcl_pkg::KEY_W{1'b1}};

    typedef struct packed {
        kcl_pkg::t_status           status;
        logic                       evicted_valid;
        logic [kcl_pkg::KEY_W-1:0]  evicted_key;
    } result_t;

    // one row of the directed table; want is used only when fixed is set
    typedef struct packed {
        logic                       op;
        logic [kcl_pkg::KEY_W-1:0]  key;
        logic                       bk;
        bit                         fixed;
        result_t                    want;
    } vector_t;

    localparam result_t NO_CHECK = '0;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_data = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_operation = 1'b0;
    logic [kcl_pkg::KEY_W-1:0]  i_key = '0;
    logic                       i_in_backing = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_status;
    logic                       o_evicted_valid;
    logic [kcl_pkg::KEY_W-1:0]  o_evicted_key;

    // mirror of the cache
    logic                       repl_mode;
    logic                       line_valid [ENTRIES];
    logic [kcl_pkg::KEY_W-1:0]  line_key [ENTRIES];
    logic [3:0]                 line_age [ENTRIES];
    logic [4:0]                 occupancy;
    logic [15:0]                victim_lfsr;

    result_t                    pending_results [$];
    vector_t                    dir_vec [$];
    logic [kcl_pkg::KEY_W-1:0]  key_pool [POOL];
    logic                       phase_mode [5];

    // receiver stall pattern state
    logic [1:0]                 rdy_mode = '0;
    logic [15:0]                rdy_pat = '0;
    logic [5:0]                 rdy_cnt = '0;

    int                         mismatches = 0;
    int                         n_items = 0;
    int                         n_checked = 0;
    int                         n_evictions = 0;
    int                         n_status [4] = '{0, 0, 0, 0};
    int                         burst_left = 0;
    int                         idle_cycles = 0;

    keyed_cache_lru_random_replace #(
        .CACHE_ENTRIES (ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_in_backing    (i_in_backing),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // insert a key, evicting first when full; returns the eviction fields
    function automatic result_t insert_key(input logic [kcl_pkg::KEY_W-1:0] k);
        result_t     r;
        int          slot;
        int          vic;
        logic [3:0]  best;
        logic [3:0]  va;
        logic        lsb;
        bit          found;
        r = '0;
        slot = -1;
        if (occupancy >= ENTRIES) begin
            if (repl_mode == kcl_pkg::MODE_RANDOM) begin
                lsb = victim_lfsr[0];
                victim_lfsr = victim_lfsr >> 1;
                if (lsb) begin
                    victim_lfsr = victim_lfsr ^ kcl_pkg::LFSR_TAPS;
                end
                vic = int'(victim_lfsr % ENTRIES);
            end else begin
                found = 1'b0;
                vic = 0;
                best = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (line_valid[i] && (!found || line_age[i] > best)) begin
                        best = line_age[i];
                        vic = i;
                        found = 1'b1;
                    end
                end
            end
            if (line_valid[vic]) begin
                va = line_age[vic];
                r.evicted_valid = 1'b1;
                r.evicted_key = line_key[vic];
                line_valid[vic] = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (line_valid[i] && line_age[i] > va) begin
                        line_age[i]--;
                    end
                end
                if (occupancy > 0) begin
                    occupancy--;
                end
                slot = vic;
            end
        end
        // lowest free slot when nothing was freed
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !line_valid[i]) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            slot = 0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i]) begin
                line_age[i]++;
            end
        end
        line_valid[slot] = 1'b1;
        line_key[slot] = k;
        line_age[slot] = '0;
        occupancy++;
        return r;
    endfunction

    // apply one request to the mirror and return the expected result
    function automatic result_t cache_access(input logic op,
                                             input logic [kcl_pkg::KEY_W-1:0] k,
                                             input logic bk);
        result_t     r;
        int          hit;
        logic [3:0]  a;
        r = '0;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && line_valid[i] && line_key[i] == k) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            // refresh: more recent entries age by one
            a = line_age[hit];
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && line_age[i] < a) begin
                    line_age[i]++;
                end
            end
            line_age[hit] = '0;
            r.status = (op == kcl_pkg::OP_RETRIEVE) ? kcl_pkg::ST_HIT : kcl_pkg::ST_STORED;
        end else if (op == kcl_pkg::OP_STORE) begin
            r = insert_key(k);
            r.status = kcl_pkg::ST_STORED;
        end else if (bk) begin
            r = insert_key(k);
            r.status = kcl_pkg::ST_BACKING;
        end else begin
            r.status = kcl_pkg::ST_NOTFOUND;
        end
        return r;
    endfunction

    // send one item, opening a new burst with a random gap when due
    task automatic send_item(input logic op, input logic [kcl_pkg::KEY_W-1:0] k,
                             input logic bk, input bit fixed, input result_t want);
        result_t  predicted;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid = 1'b1;
        i_operation = op;
        i_key = k;
        i_in_backing = bk;
        do @(posedge i_clk); while (!o_ready);
        predicted = cache_access(op, k, bk);
        pending_results.push_back(fixed ? want : predicted);
        n_items++;
        n_status[predicted.status]++;
        if (predicted.evicted_valid) begin
            n_evictions++;
        end
        @(negedge i_clk);
    endtask

    // hold off input until every expected result is out
    task automatic drain();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        repl_mode = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver stalls: always ready, coin flip, rotating pattern, mostly stalled
    always @(negedge i_clk) begin : ready_gen
        logic nxt;
        if (rdy_cnt == 0) begin
            rdy_mode = 2'($urandom_range(0, 3));
            rdy_pat = 16'($urandom);
        end
        case (rdy_mode)
            2'd0: nxt = 1'b1;
            2'd1: nxt = 1'($urandom_range(0, 1));
            2'd2: nxt = rdy_pat[rdy_cnt[3:0]];
            default: nxt = ($urandom_range(0, 3) == 0);
        endcase
        rdy_cnt = rdy_cnt + 6'd1;
        i_ready <= nxt;
    end

    // result checker
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected (status %0d)", o_status));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_status !== want.status) begin
                    report($sformatf("status got %0d expected %0d", o_status, want.status));
                end
                if (o_evicted_valid !== want.evicted_valid) begin
                    report($sformatf("evicted_valid got %0b expected %0b",
                                     o_evicted_valid, want.evicted_valid));
                end
                if (o_evicted_key !== want.evicted_key) begin
                    report($sformatf("evicted_key got %08h expected %08h",
                                     o_evicted_key, want.evicted_key));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                         pool_n;
        int                         pct;
        logic                       op;
        logic                       bk;
        logic [kcl_pkg::KEY_W-1:0]  k;

        phase_mode = '{kcl_pkg::MODE_RANDOM, kcl_pkg::MODE_LRU, kcl_pkg::MODE_RANDOM,
                       kcl_pkg::MODE_LRU, kcl_pkg::MODE_RANDOM};

        // mirror reset
        repl_mode = kcl_pkg::MODE_LRU;
        occupancy = '0;
        victim_lfsr = kcl_pkg::LFSR_SEED;
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i] = '0;
            line_age[i] = '0;
        end

        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < POOL; i++) begin
            key_pool[i] = kcl_pkg::KEY_W'($urandom);
        end

        // directed table
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, '0, 1'b0, 1'b1,
                            '{kcl_pkg::ST_NOTFOUND, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_STORE, '0, 1'b0, 1'b1,
                            '{kcl_pkg::ST_STORED, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_STORE, KEY_MAX, 1'b0, 1'b1,
                            '{kcl_pkg::ST_STORED, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_STORE, '0, 1'b0, 1'b1,
                            '{kcl_pkg::ST_STORED, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, '0, 1'b0, 1'b1,
                            '{kcl_pkg::ST_HIT, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, KEY_MAX, 1'b1, 1'b1,
                            '{kcl_pkg::ST_HIT, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, 31'd5, 1'b1, 1'b1,
                            '{kcl_pkg::ST_BACKING, 1'b0, '0}});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, 31'd6, 1'b0, 1'b1,
                            '{kcl_pkg::ST_NOTFOUND, 1'b0, '0}});
        // store ignores the backing flag
        dir_vec.push_back('{kcl_pkg::OP_STORE, 31'd7, 1'b1, 1'b1,
                            '{kcl_pkg::ST_STORED, 1'b0, '0}});
        // fill the cache, then force LRU evictions
        for (int i = 0; i < 12; i++) begin
            dir_vec.push_back('{kcl_pkg::OP_STORE, kcl_pkg::KEY_W'(100 + i), 1'b0, 1'b0,
                                NO_CHECK});
        end
        dir_vec.push_back('{kcl_pkg::OP_STORE, 31'd200, 1'b0, 1'b0, NO_CHECK});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, 31'd201, 1'b1, 1'b0, NO_CHECK});
        dir_vec.push_back('{kcl_pkg::OP_RETRIEVE, 31'h2AAA_AAAA, 1'b0, 1'b0, NO_CHECK});

        // reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_mode(kcl_pkg::MODE_LRU);
        foreach (dir_vec[i]) begin
            send_item(dir_vec[i].op, dir_vec[i].key, dir_vec[i].bk, dir_vec[i].fixed,
                      dir_vec[i].want);
        end

        // random phases, alternating replacement mode
        for (int p = 0; p < 5; p++) begin
            write_mode(phase_mode[p]);
            pool_n = $urandom_range(10, POOL);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                op = ($urandom_range(0, 99) < 40) ? kcl_pkg::OP_STORE : kcl_pkg::OP_RETRIEVE;
                pct = $urandom_range(0, 99);
                k = (pct < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                               : kcl_pkg::KEY_W'($urandom);
                bk = 1'($urandom_range(0, 1));
                send_item(op, k, bk, 1'b0, NO_CHECK);
            end
        end

        // wind down
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("covered %0d items in both modes: %0d hits, %0d backing inserts,",
                 n_items, n_status[kcl_pkg::ST_HIT], n_status[kcl_pkg::ST_BACKING]);
        $display("%0d not found, %0d stores, %0d evictions, %0d checked, %0d mismatches",
                 n_status[kcl_pkg::ST_NOTFOUND], n_status[kcl_pkg::ST_STORED],
                 n_evictions, n_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
